@@ hdl/canrx_pkg.sv @@
// Shared types and constants for the CAN receive filter and router.
package canrx_pkg;

  // Field widths
  localparam int unsigned ID_W     = 29;
  localparam int unsigned STD_ID_W = 11;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned HND_W    = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CNT_W    = 5;
  // Width used to compare cell indexes against slots and the active count
  localparam int unsigned CMP_W    = 7;
  // Widest handle a cell may store
  localparam int unsigned HND_MAX_W = 16;

  // Element word 0 layout
  localparam int unsigned EXT_BIT    = 30;
  localparam int unsigned STD_ID_LSB = 18;
  // Element word 1 layout
  localparam int unsigned DLC_LSB    = 16;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  // One input item
  typedef struct packed {
    logic                command;
    logic [SLOT_W-1:0]   filter_slot;
    logic [ID_W-1:0]     filter_id;
    logic [ID_W-1:0]     filter_mask;
    logic                filter_type;
    logic [HND_W-1:0]    filter_handle;
    logic [WORD_W-1:0]   element_word0;
    logic [WORD_W-1:0]   element_word1;
    logic [WORD_W-1:0]   element_word2;
    logic [WORD_W-1:0]   element_word3;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [ID_W-1:0]     frame_id;
    logic                frame_extended;
    logic [LEN_W-1:0]    frame_length;
    logic [HND_W-1:0]    route_handle;
    logic [SLOT_W-1:0]   matched_entry;
    logic [WORD_W-1:0]   payload_low;
    logic [WORD_W-1:0]   payload_high;
  } out_item_t;

  // Token handed from cell to cell: a filter load or a decoded frame
  typedef struct packed {
    logic                valid;
    logic                is_frame;
    // load part
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     ld_id;
    logic [ID_W-1:0]     ld_mask;
    logic                ld_type;
    logic [HND_W-1:0]    ld_handle;
    // frame part
    logic [ID_W-1:0]     fr_id;
    logic                fr_ext;
    logic [LEN_W-1:0]    fr_len;
    logic [WORD_W-1:0]   fr_low;
    logic [WORD_W-1:0]   fr_high;
    // match status
    logic                hit;
    logic [HND_W-1:0]    hit_handle;
    logic [SLOT_W-1:0]   hit_entry;
  } canrx_tok_t;

endpackage

@@ hdl/canrx_decode.sv @@
// Input stage: decodes a command into a chain token and registers it.
module canrx_decode
  import canrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  in_item_t   item,
  output canrx_tok_t tok
);

  canrx_tok_t tok_r;
  canrx_tok_t tok_nxt;
  logic       ext;
  logic [LEN_W-1:0] dlc;

  // Field extraction from the element words
  always_comb begin
    ext = item.element_word0[EXT_BIT];
    dlc = item.element_word1[DLC_LSB +: LEN_W];

    tok_nxt            = '0;
    tok_nxt.valid      = take;
    tok_nxt.is_frame   = (item.command == CMD_FRAME);
    tok_nxt.slot       = item.filter_slot;
    tok_nxt.ld_id      = item.filter_id;
    tok_nxt.ld_mask    = item.filter_mask;
    tok_nxt.ld_type    = item.filter_type;
    tok_nxt.ld_handle  = item.filter_handle;
    tok_nxt.fr_ext     = ext;
    if (ext) begin
      tok_nxt.fr_id = item.element_word0[ID_W-1:0];
    end else begin
      tok_nxt.fr_id = ID_W'(item.element_word0[STD_ID_LSB +: STD_ID_W]);
    end
    // codes above eight clamp to eight
    tok_nxt.fr_len     = (dlc > MAX_LEN) ? MAX_LEN : dlc;
    tok_nxt.fr_low     = item.element_word2;
    tok_nxt.fr_high    = item.element_word3;
  end

  // Valid is control, the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.is_frame   <= tok_nxt.is_frame;
    tok_r.slot       <= tok_nxt.slot;
    tok_r.ld_id      <= tok_nxt.ld_id;
    tok_r.ld_mask    <= tok_nxt.ld_mask;
    tok_r.ld_type    <= tok_nxt.ld_type;
    tok_r.ld_handle  <= tok_nxt.ld_handle;
    tok_r.fr_id      <= tok_nxt.fr_id;
    tok_r.fr_ext     <= tok_nxt.fr_ext;
    tok_r.fr_len     <= tok_nxt.fr_len;
    tok_r.fr_low     <= tok_nxt.fr_low;
    tok_r.fr_high    <= tok_nxt.fr_high;
    tok_r.hit        <= tok_nxt.hit;
    tok_r.hit_handle <= tok_nxt.hit_handle;
    tok_r.hit_entry  <= tok_nxt.hit_entry;
  end

  assign tok = tok_r;

endmodule

@@ hdl/canrx_cell.sv @@
// One filter cell: holds one entry, loads it or matches a passing frame.
module canrx_cell
  import canrx_pkg::*;
#(
  parameter int unsigned CELL_IDX    = 0,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] active,
  input  canrx_tok_t       tok_in,
  output canrx_tok_t       tok_out
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_IDX);

  // Stored entry, no reset: the user must see that it is read only after a load
  logic [ID_W-1:0]        ent_id_r;
  logic [ID_W-1:0]        ent_mask_r;
  logic                   ent_type_r;
  logic [HANDLE_BITS-1:0] ent_handle_r;

  logic                   load_here;
  logic                   enabled;
  logic                   match;
  logic [HND_MAX_W-1:0]   ld_handle_ext;
  logic [HND_MAX_W-1:0]   ent_handle_ext;
  canrx_tok_t             tok_nxt;
  canrx_tok_t             tok_r;

  assign load_here = tok_in.valid && !tok_in.is_frame
                     && (CMP_W'(tok_in.slot) == MY_IDX);
  assign enabled   = (CMP_W'(active) > MY_IDX);
  assign ld_handle_ext  = HND_MAX_W'(tok_in.ld_handle);
  assign ent_handle_ext = HND_MAX_W'(ent_handle_r);

  // Entry write
  always_ff @(posedge clk) begin
    if (load_here) begin
      ent_id_r     <= tok_in.ld_id;
      ent_mask_r   <= tok_in.ld_mask;
      ent_type_r   <= tok_in.ld_type;
      ent_handle_r <= ld_handle_ext[HANDLE_BITS-1:0];
    end
  end

  // Compare: same type and masked ids equal; first hit wins
  always_comb begin
    match = tok_in.valid && tok_in.is_frame && !tok_in.hit && enabled
            && (ent_type_r == tok_in.fr_ext)
            && (((tok_in.fr_id ^ ent_id_r) & ent_mask_r) == '0);
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit        = 1'b1;
      tok_nxt.hit_handle = ent_handle_ext[HND_W-1:0];
      tok_nxt.hit_entry  = MY_IDX[SLOT_W-1:0];
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.is_frame   <= tok_nxt.is_frame;
    tok_r.slot       <= tok_nxt.slot;
    tok_r.ld_id      <= tok_nxt.ld_id;
    tok_r.ld_mask    <= tok_nxt.ld_mask;
    tok_r.ld_type    <= tok_nxt.ld_type;
    tok_r.ld_handle  <= tok_nxt.ld_handle;
    tok_r.fr_id      <= tok_nxt.fr_id;
    tok_r.fr_ext     <= tok_nxt.fr_ext;
    tok_r.fr_len     <= tok_nxt.fr_len;
    tok_r.fr_low     <= tok_nxt.fr_low;
    tok_r.fr_high    <= tok_nxt.fr_high;
    tok_r.hit        <= tok_nxt.hit;
    tok_r.hit_handle <= tok_nxt.hit_handle;
    tok_r.hit_entry  <= tok_nxt.hit_entry;
  end

  assign tok_out = tok_r;

endmodule

@@ hdl/can_rx_decode_filter_route.sv @@
// Top level: CAN receive acceptance filter built as a chain of filter cells.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | start / busy         | in_data  (in_item_t)
//  result   | out_valid strobe     | out_data (out_item_t)
//  config   | cfg_we               | cfg_wdata (active filter count)
//
// A command enters every cycle; busy stays low. Each token passes one cell
// per cycle: a frame is registered in the decode stage and then in one cell
// per filter before its result shows. Loads ride the same chain, so every
// frame sees exactly the entries loaded before it. Reset clears the token
// valid bits and the active count; entries are not cleared. The receiver
// cannot stall: each result strobes for one cycle.
module can_rx_decode_filter_route
  import canrx_pkg::*;
#(
  parameter int unsigned NUM_FILTERS = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] active_r;
  logic             take;
  canrx_tok_t       link [NUM_FILTERS+1];

  assign busy = 1'b0;
  assign take = start && !busy;

  // Active filter count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  canrx_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .tok   (link[0])
  );

  // Filter cell chain
  for (genvar g = 0; g < NUM_FILTERS; g++) begin : g_cell
    canrx_cell #(
      .CELL_IDX    (g),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (active_r),
      .tok_in  (link[g]),
      .tok_out (link[g+1])
    );
  end

  // Result from the last cell
  assign out_valid = link[NUM_FILTERS].valid && link[NUM_FILTERS].is_frame
                     && link[NUM_FILTERS].hit;
  assign out_data.frame_id       = link[NUM_FILTERS].fr_id;
  assign out_data.frame_extended = link[NUM_FILTERS].fr_ext;
  assign out_data.frame_length   = link[NUM_FILTERS].fr_len;
  assign out_data.route_handle   = link[NUM_FILTERS].hit_handle;
  assign out_data.matched_entry  = link[NUM_FILTERS].hit_entry;
  assign out_data.payload_low    = link[NUM_FILTERS].fr_low;
  assign out_data.payload_high   = link[NUM_FILTERS].fr_high;

  // A load never turns into a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_data.command == CMD_LOAD)) |-> ##(NUM_FILTERS+1) !out_valid)
    else $error("load command produced a result");

  // A frame with no active filter never matches
  a_none_active: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (active_r == '0) && !cfg_we) |-> ##(NUM_FILTERS+1) !out_valid)
    else $error("frame matched with no active filter");

  // Clamped length
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_length <= MAX_LEN))
    else $error("frame length above eight");

  // Standard ids fit in eleven bits
  a_std_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.frame_extended) |-> (out_data.frame_id[ID_W-1:STD_ID_W] == '0))
    else $error("standard id wider than eleven bits");

  // Matched entry lies below the active count
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CMP_W'(out_data.matched_entry) < CMP_W'(active_r)))
    else $error("matched entry outside active filters");

endmodule
